@@ sv/lchc_pkg.sv @@
// ----------------------------------------------------------------------------
// lchc_pkg: shared types and constants for the LRU cache hit counter
// Holds the sequencer state type and the fixed field widths.
// ----------------------------------------------------------------------------
package lchc_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned COUNT_W     = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_UPDATE,
    ST_OUT
  } state_e;

endpackage

@@ sv/lru_cache_hit_counter_top.sv @@
// ----------------------------------------------------------------------------
// lru_cache_hit_counter_top: fully associative LRU key cache with hit count
//
// Input channel (in_valid_i / in_stall_o) carries one key and a start flag.
// Output channel (out_valid_o / out_stall_i) returns the hit flag and the
// saturating hit count of the current sequence, one result beat per input.
// cfg_we_i / cfg_wdata_i write the capacity register. The user must write it
// only while the block is idle; the block itself does not enforce this.
//
// One comparator walks the key memory one entry a cycle. A beat passes
// through SCAN over every entry, DRAIN for the registered memory read,
// UPDATE for ranks and memory, and OUT, where the result is presented
// until taken. A new beat is taken only once the previous result has
// been delivered.
//
// Reset empties the cache, zeroes the count and sets the capacity to 16.
// No clearing pass is needed: entries are gated by per-entry valid bits.
// While the receiver stalls, the result holds and the input stays stalled.
// ----------------------------------------------------------------------------
module lru_cache_hit_counter_top #(
  parameter int unsigned ENTRIES = lchc_pkg::ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lchc_pkg::CAP_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [lchc_pkg::KEY_W-1:0]   request_key_i,
  input  logic                                start_sequence_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                hit_o,
  output logic [lchc_pkg::COUNT_W-1:0]        hit_count_o
);
  import lchc_pkg::*;

  localparam int unsigned IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OW  = $clog2(ENTRIES + 1);
  localparam int unsigned CW  = ((OW > CAP_W) ? OW : CAP_W) + 1;
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  state_e state_q, state_d;

  logic [CAP_W-1:0]   capacity_q;
  logic [IW-1:0]      idx_q;
  logic               cmp_vld_q;
  logic [IW-1:0]      cmp_idx_q;
  logic [KEY_W-1:0]   key_q;
  logic [KEY_W-1:0]   rdata_q;

  logic               found_q, free_q, vic_q;
  logic [IW-1:0]      found_idx_q, free_idx_q, vic_idx_q;
  logic [IW-1:0]      found_rank_q;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IW-1:0]      rank_q [ENTRIES];
  logic [IW-1:0]      rank_d [ENTRIES];
  logic [OW-1:0]      occ_q, occ_d;
  logic [COUNT_W-1:0] hit_total_q, hit_total_d;

  logic [KEY_W-1:0]   key_mem [ENTRIES];

  logic               in_acc, out_acc;
  logic               rd_en, scanning, updating;
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic               age_en, age_all, tgt_en;
  logic [IW-1:0]      age_limit, tgt_idx;
  logic               miss_full;
  logic [CW-1:0]      cap_eff;
  logic               cmp_valid, cmp_match, cmp_victim;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_SCAN;
      ST_SCAN:   if (idx_q == LAST) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_OUT;
      ST_OUT:    if (out_acc) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    rd_en       = 1'b0;
    scanning    = 1'b0;
    updating    = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o  = 1'b0;
      ST_SCAN: begin
        rd_en    = 1'b1;
        scanning = 1'b1;
      end
      ST_DRAIN:  scanning    = 1'b1;
      ST_UPDATE: updating    = 1'b1;
      ST_OUT:    out_valid_o = 1'b1;
      default:   in_stall_o  = 1'b1;
    endcase
  end

  assign hit_o       = found_q;
  assign hit_count_o = hit_total_q;

  // compare stage
  assign cmp_valid  = scanning && cmp_vld_q && valid_q[cmp_idx_q];
  assign cmp_match  = cmp_valid && (rdata_q == key_q);
  assign cmp_victim = cmp_valid && ((CW'(rank_q[cmp_idx_q]) + CW'(1)) == CW'(occ_q));

  assign cap_eff   = (CW'(capacity_q) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(capacity_q);
  assign miss_full = (CW'(occ_q) + CW'(1)) > cap_eff;

  // update decisions
  always_comb begin
    age_en      = 1'b0;
    age_all     = 1'b0;
    age_limit   = found_rank_q;
    tgt_en      = 1'b0;
    tgt_idx     = found_idx_q;
    mem_we      = 1'b0;
    mem_waddr   = free_idx_q;
    occ_d       = occ_q;
    hit_total_d = hit_total_q;
    if (updating) begin
      if (found_q) begin
        age_en = 1'b1;
        tgt_en = 1'b1;
        if (hit_total_q != '1) hit_total_d = hit_total_q + COUNT_W'(1);
      end else if (miss_full) begin
        if (vic_q) begin
          age_en    = 1'b1;
          age_limit = IW'(occ_q - OW'(1));
          tgt_en    = 1'b1;
          tgt_idx   = vic_idx_q;
          mem_we    = 1'b1;
          mem_waddr = vic_idx_q;
        end
      end else if (free_q) begin
        age_en  = 1'b1;
        age_all = 1'b1;
        tgt_en  = 1'b1;
        tgt_idx = free_idx_q;
        mem_we  = 1'b1;
        occ_d   = occ_q + OW'(1);
      end
    end
    if (in_acc && start_sequence_i) begin
      occ_d       = '0;
      hit_total_d = '0;
    end
  end

  // per-entry rank and valid lanes
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i]  = rank_q[i];
      valid_d[i] = valid_q[i];
      if (age_en && valid_q[i] && (age_all || rank_q[i] < age_limit)) begin
        rank_d[i] = rank_q[i] + IW'(1);
      end
      if (tgt_en && tgt_idx == IW'(i)) begin
        rank_d[i]  = '0;
        valid_d[i] = 1'b1;
      end
      if (in_acc && start_sequence_i) valid_d[i] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      capacity_q  <= CAP_RESET;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      vic_q       <= 1'b0;
      valid_q     <= '0;
      occ_q       <= '0;
      hit_total_q <= '0;
      for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      occ_q       <= occ_d;
      hit_total_q <= hit_total_d;
      rank_q      <= rank_d;
      cmp_vld_q   <= rd_en;
      if (cfg_we_i) capacity_q <= cfg_wdata_i;
      if (in_acc) begin
        idx_q   <= '0;
        found_q <= 1'b0;
        free_q  <= 1'b0;
        vic_q   <= 1'b0;
      end else begin
        if (rd_en) idx_q <= idx_q + IW'(1);
        if (cmp_match && !found_q) found_q <= 1'b1;
        if (scanning && cmp_vld_q && !valid_q[cmp_idx_q] && !free_q) free_q <= 1'b1;
        if (cmp_victim && !vic_q) vic_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) key_q <= request_key_i;
    if (rd_en) cmp_idx_q <= idx_q;
    if (cmp_match && !found_q) begin
      found_idx_q  <= cmp_idx_q;
      found_rank_q <= rank_q[cmp_idx_q];
    end
    if (scanning && cmp_vld_q && !valid_q[cmp_idx_q] && !free_q) free_idx_q <= cmp_idx_q;
    if (cmp_victim && !vic_q) vic_idx_q <= cmp_idx_q;
  end

  // key memory
  always_ff @(posedge clk_i) begin
    if (mem_we) key_mem[mem_waddr] <= key_q;
    if (rd_en) rdata_q <= key_mem[idx_q];
  end

  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == OW'($countones(valid_q)))
    else $error("occupancy does not match valid entries");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(occ_q) <= CW'(ENTRIES))
    else $error("occupancy above entry count");

  a_hit_increments: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && found_q && hit_total_q != '1)
      |=> hit_total_q == $past(hit_total_q) + COUNT_W'(1))
    else $error("hit count did not advance on hit");

  a_count_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |=> hit_total_q >= $past(hit_total_q))
    else $error("hit count dropped mid-beat");

endmodule
